[rtl/core/safs_pkg.sv]
package safs_pkg;

	// Command codes carried in the input tuser field.
	localparam logic [1:0] CMD_PLAY   = 2'd0;
	localparam logic [1:0] CMD_UPDATE = 2'd1;
	localparam logic [1:0] CMD_STOP   = 2'd2;
	localparam logic [1:0] CMD_LOAD   = 2'd3;

	// Loop modes.
	localparam logic [1:0] MODE_ONCE      = 2'd0;
	localparam logic [1:0] MODE_ONCE_HOLD = 2'd1;
	localparam logic [1:0] MODE_LOOP      = 2'd2;
	localparam logic [1:0] MODE_PINGPONG  = 2'd3;

	// Field widths.
	localparam int TIME_W  = 32;
	localparam int DUR_W   = 16;
	localparam int COUNT_W = 5;

	// A full cycle of at most 31 frames, inner ones counted twice, fits here.
	localparam int PERIOD_W = 23;

	// Request to the remainder unit.
	typedef struct packed {
		logic                start;
		logic [TIME_W-1:0]   dividend;
		logic [PERIOD_W-1:0] divisor;
	} rem_req_t;

	// Response of the remainder unit.
	typedef struct packed {
		logic                done;
		logic [PERIOD_W-1:0] rem;
	} rem_rsp_t;

endpackage

[rtl/core/safs_dur_store.sv]
module safs_dur_store #(
	parameter int DEPTH = 16,
	parameter int AW    = 4
) (
	input  logic                        clk,
	input  logic                        wr_en,
	input  logic [AW-1:0]               wr_addr,
	input  logic [safs_pkg::DUR_W-1:0]  wr_data,
	input  logic [AW-1:0]               rd_addr,
	output logic [safs_pkg::DUR_W-1:0]  rd_data
);

	logic [safs_pkg::DUR_W-1:0] mem_q [DEPTH];

	// One write port and one registered read port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end

endmodule

[rtl/core/safs_rem.sv]
module safs_rem (
	input  logic                clk,
	input  logic                arst_n,
	input  safs_pkg::rem_req_t  req,
	output safs_pkg::rem_rsp_t  rsp
);

	localparam int TW = safs_pkg::TIME_W;
	localparam int PW = safs_pkg::PERIOD_W;

	logic          busy_q;
	logic          done_q;
	logic [4:0]    cnt_q;
	logic [TW-1:0] dvd_q;
	logic [PW-1:0] div_q;
	logic [PW-1:0] r_q;
	logic [PW:0]   trial;
	logic [PW:0]   diff;

	// One restoring step: bring in the next dividend bit and subtract if it fits.
	assign trial = {r_q, dvd_q[TW-1]};
	assign diff  = trial - {1'b0, div_q};

	// Control of the bit-serial sweep over the dividend.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'(TW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath of the sweep.
	always_ff @(posedge clk) begin
		if (req.start) begin
			dvd_q <= req.dividend;
			div_q <= req.divisor;
			r_q   <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[TW-2:0], 1'b0};
			if (trial >= {1'b0, div_q}) begin
				r_q <= PW'(diff);
			end else begin
				r_q <= PW'(trial);
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.rem  = r_q;

endmodule

[rtl/core/sprite_animation_frame_sequencer_top.sv]
// Play, stop and load go straight to the result state. An update first checks whether
// there is anything to do, then walks the frames one at a time; loop and pingpong updates
// first sum the cycle length, check whether whole cycles can be skipped and run the 32-step
// remainder unit if so. The next request is taken the cycle after a result is registered,
// even while it waits in the output register.
// Asynchronous active-low reset clears sequencer and animation state; the store is kept.
module sprite_animation_frame_sequencer_top #(
	parameter int MAX_FRAMES = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// Fields from bit 0: now_ms[32], anim_id[8], frame_count[5], loop_mode[2],
	// uniform_ms[16], use_table[1], table_index[4], table_value[16], zero pad.
	input  logic [87:0] s_tdata,
	// Fields from bit 0: command[2].
	input  logic [1:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// Fields from bit 0: changed[1], frame_index[4], visible[1], finished[1], zero pad.
	output logic [7:0]  m_tdata
);

	localparam int TW     = safs_pkg::TIME_W;
	localparam int DW     = safs_pkg::DUR_W;
	localparam int CW     = safs_pkg::COUNT_W;
	localparam int PW     = safs_pkg::PERIOD_W;
	localparam int FC_MAX = (MAX_FRAMES > 31) ? 31 : MAX_FRAMES;
	localparam int IW     = $clog2(FC_MAX);
	localparam int SD     = (MAX_FRAMES < 16) ? MAX_FRAMES : 16;
	localparam int SAW    = $clog2(SD);

	typedef enum logic [8:0] {
		S_IDLE     = 9'b000000001,
		S_CHECK    = 9'b000000010,
		S_SUM_RD   = 9'b000000100,
		S_SUM_ACC  = 9'b000001000,
		S_SKIP     = 9'b000010000,
		S_DIV      = 9'b000100000,
		S_WALK_RD  = 9'b001000000,
		S_WALK_CHK = 9'b010000000,
		S_DONE     = 9'b100000000
	} state_t;

	state_t state_q;

	// Request fields.
	logic [1:0]    in_cmd;
	logic [TW-1:0] in_now;
	logic [7:0]    in_id;
	logic [CW-1:0] in_fc;
	logic [1:0]    in_mode;
	logic [DW-1:0] in_uni;
	logic          in_tab;
	logic [3:0]    in_tidx;
	logic [DW-1:0] in_tval;
	logic          accept;

	assign in_cmd  = s_tuser;
	assign in_now  = s_tdata[31:0];
	assign in_id   = s_tdata[39:32];
	assign in_fc   = s_tdata[44:40];
	assign in_mode = s_tdata[46:45];
	assign in_uni  = s_tdata[62:47];
	assign in_tab  = s_tdata[63];
	assign in_tidx = s_tdata[67:64];
	assign in_tval = s_tdata[83:68];

	assign s_tready = (state_q == S_IDLE);
	assign accept   = s_tvalid && s_tready;

	// Animation state.
	logic          active_q;
	logic [7:0]    id_q;
	logic [CW-1:0] fiu_q;
	logic [1:0]    mode_q;
	logic [DW-1:0] uni_q;
	logic          tab_q;
	logic [TW-1:0] epoch_q;
	logic [IW-1:0] frame_q;
	logic          fwd_q;
	logic          ended_q;

	// Working registers of one update.
	logic [TW-1:0] now_q;
	logic [TW-1:0] elapsed_q;
	logic [IW-1:0] start_q;
	logic [CW-1:0] idx_q;
	logic [PW-1:0] period_q;
	logic          zero_q;
	logic          chg_en_q;

	// Output register.
	logic          out_valid_q;
	logic [7:0]    out_data_q;

	logic [CW-1:0] fn5;
	logic [CW-1:0] last5;
	logic [CW-1:0] fc_clamped;
	logic [7:0]    cur_id;
	logic [DW-1:0] rd_data;
	logic [DW-1:0] dur;
	logic [SAW-1:0] rd_addr;
	logic          wr_en;
	logic [DW:0]   add_term;
	logic          walk_go;
	logic          upd_exit;
	logic          skip_go;
	logic          vis;
	logic          chg;

	safs_pkg::rem_req_t rem_req;
	safs_pkg::rem_rsp_t rem_rsp;

	assign fn5        = CW'(frame_q);
	assign last5      = fiu_q - CW'(1);
	assign fc_clamped = (in_fc > CW'(FC_MAX)) ? CW'(FC_MAX) : in_fc;
	assign cur_id     = active_q ? id_q : 8'd0;

	// Duration store: written by load requests, read by the sequencer.
	assign wr_en   = accept && (in_cmd == safs_pkg::CMD_LOAD) && (32'(in_tidx) < MAX_FRAMES);
	assign rd_addr = (state_q == S_SUM_RD) ? SAW'(idx_q) : SAW'(frame_q);

	safs_dur_store #(
		.DEPTH (SD),
		.AW    (SAW)
	) u_store (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (SAW'(in_tidx)),
		.wr_data (in_tval),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	assign dur = tab_q ? rd_data : uni_q;

	// Inner pingpong frames count twice in the cycle length.
	assign add_term = ((mode_q == safs_pkg::MODE_PINGPONG) && (idx_q != '0) && (idx_q != last5))
		? {dur, 1'b0} : {1'b0, dur};

	// Decisions taken by the sequencer.
	assign upd_exit = !active_q || ended_q || (fiu_q == '0) ||
		((fiu_q == CW'(1)) && mode_q[1]);
	assign skip_go  = !zero_q && (period_q != '0) && (elapsed_q >= TW'(period_q));
	assign walk_go  = (dur != '0) && !ended_q && (elapsed_q >= TW'(dur));

	// Remainder unit for skipping whole cycles of elapsed time.
	assign rem_req.start    = (state_q == S_SKIP) && skip_go;
	assign rem_req.dividend = elapsed_q;
	assign rem_req.divisor  = period_q;

	safs_rem u_rem (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (rem_req),
		.rsp    (rem_rsp)
	);

	// Result fields.
	assign vis = active_q && (fiu_q != '0) && !(ended_q && (mode_q == safs_pkg::MODE_ONCE));
	assign chg = chg_en_q && ((ended_q && (mode_q == safs_pkg::MODE_ONCE)) || (frame_q != start_q));

	// Sequencer and animation state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			active_q    <= 1'b0;
			id_q        <= '0;
			fiu_q       <= '0;
			mode_q      <= '0;
			uni_q       <= '0;
			tab_q       <= 1'b0;
			epoch_q     <= '0;
			frame_q     <= '0;
			fwd_q       <= 1'b1;
			ended_q     <= 1'b1;
			chg_en_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						chg_en_q <= 1'b0;
						state_q  <= S_DONE;
						case (in_cmd)
							safs_pkg::CMD_PLAY: begin
								if (in_id != cur_id) begin
									if (in_id == 8'd0) begin
										active_q <= 1'b0;
										id_q     <= '0;
										frame_q  <= '0;
										fwd_q    <= 1'b1;
										ended_q  <= 1'b1;
									end else begin
										active_q <= 1'b1;
										id_q     <= in_id;
										fiu_q    <= fc_clamped;
										mode_q   <= in_mode;
										uni_q    <= in_uni;
										tab_q    <= in_tab;
										epoch_q  <= in_now;
										frame_q  <= '0;
										fwd_q    <= 1'b1;
										ended_q  <= (fc_clamped == '0);
									end
								end
							end
							safs_pkg::CMD_UPDATE: begin
								state_q <= S_CHECK;
							end
							safs_pkg::CMD_STOP: begin
								active_q <= 1'b0;
								id_q     <= '0;
								frame_q  <= '0;
								fwd_q    <= 1'b1;
								ended_q  <= 1'b1;
							end
							default: begin
							end
						endcase
					end
				end
				S_CHECK: begin
					if (upd_exit) begin
						state_q <= S_DONE;
					end else begin
						chg_en_q <= 1'b1;
						state_q  <= mode_q[1] ? S_SUM_RD : S_WALK_RD;
					end
				end
				S_SUM_RD: begin
					state_q <= S_SUM_ACC;
				end
				S_SUM_ACC: begin
					state_q <= (idx_q == last5) ? S_SKIP : S_SUM_RD;
				end
				S_SKIP: begin
					state_q <= skip_go ? S_DIV : S_WALK_RD;
				end
				S_DIV: begin
					if (rem_rsp.done) begin
						epoch_q <= now_q - TW'(rem_rsp.rem);
						state_q <= S_WALK_RD;
					end
				end
				S_WALK_RD: begin
					state_q <= S_WALK_CHK;
				end
				S_WALK_CHK: begin
					if (walk_go) begin
						epoch_q <= epoch_q + TW'(dur);
						state_q <= S_WALK_RD;
						// Step one frame in the current loop mode.
						case (mode_q)
							safs_pkg::MODE_ONCE, safs_pkg::MODE_ONCE_HOLD: begin
								if (fn5 < last5) begin
									frame_q <= IW'(fn5 + CW'(1));
								end else begin
									ended_q <= 1'b1;
								end
							end
							safs_pkg::MODE_LOOP: begin
								frame_q <= (fn5 >= last5) ? '0 : IW'(fn5 + CW'(1));
							end
							default: begin
								if (fwd_q) begin
									if (fn5 >= last5) begin
										fwd_q   <= 1'b0;
										frame_q <= IW'(fn5 - CW'(1));
									end else begin
										frame_q <= IW'(fn5 + CW'(1));
									end
								end else begin
									if (fn5 == '0) begin
										fwd_q   <= 1'b1;
										frame_q <= IW'(fn5 + CW'(1));
									end else begin
										frame_q <= IW'(fn5 - CW'(1));
									end
								end
							end
						endcase
					end else begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (!out_valid_q || m_tready) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Working registers of an update; no reset needed.
	always_ff @(posedge clk) begin
		if (accept) begin
			now_q <= in_now;
		end
		case (state_q)
			S_CHECK: begin
				elapsed_q <= now_q - epoch_q;
				start_q   <= frame_q;
				idx_q     <= '0;
				period_q  <= '0;
				zero_q    <= 1'b0;
			end
			S_SUM_ACC: begin
				period_q <= period_q + PW'(add_term);
				idx_q    <= idx_q + CW'(1);
				if (dur == '0) begin
					zero_q <= 1'b1;
				end
			end
			S_DIV: begin
				if (rem_rsp.done) begin
					elapsed_q <= TW'(rem_rsp.rem);
				end
			end
			S_WALK_CHK: begin
				if (walk_go) begin
					elapsed_q <= elapsed_q - TW'(dur);
				end
			end
			S_DONE: begin
				if (!out_valid_q || m_tready) begin
					out_data_q <= {1'b0, ended_q, vis, 4'(frame_q), chg};
				end
			end
			default: begin
			end
		endcase
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

`ifndef SYNTHESIS
	// A taken request always keeps the sequencer busy in the next cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !s_tready)
		else $error("sequencer ready right after taking a request");

	// The current frame stays inside the loaded animation.
	assert property (@(posedge clk) disable iff (!arst_n)
		(active_q && (fiu_q != '0)) |-> (fn5 < fiu_q))
		else $error("frame index beyond frame count");

	// Cycle skipping only happens for loop and pingpong animations.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV) |-> mode_q[1])
		else $error("remainder step in a once mode");

	// The remainder unit reports only while the sequencer waits for it.
	assert property (@(posedge clk) disable iff (!arst_n)
		rem_rsp.done |-> (state_q == S_DIV))
		else $error("remainder result outside the divide step");
`endif

endmodule
